// File: hw/rtl/lpw_pkg.sv
// Shared types, codes and register defaults for the link presence watchdog.
package lpw_pkg;

    // Link state codes
    localparam logic [1:0] ST_UNKNOWN  = 2'd0;
    localparam logic [1:0] ST_DETECTED = 2'd1;
    localparam logic [1:0] ST_READY    = 2'd2;
    localparam logic [1:0] ST_LOST     = 2'd3;

    // Publish event codes
    localparam logic [1:0] EVT_NONE      = 2'd0;
    localparam logic [1:0] EVT_DETECTED  = 2'd1;
    localparam logic [1:0] EVT_CONNECTED = 2'd2;
    localparam logic [1:0] EVT_LOST      = 2'd3;

    // Request kinds
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_POLL   = 1'b1;

    // Device type that gets the one-time setup
    localparam logic [1:0] DEV_BODY = 2'd1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_READY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_SEARCH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_RECOVERY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_READY_DELAY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_TIMEOUT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_CONFIRM   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_WINDOW    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REINIT_IVL     = 3'd7;

    // Register defaults after reset
    localparam logic [15:0] RST_PROBE_READY    = 16'd5000;
    localparam logic [15:0] RST_PROBE_SEARCH   = 16'd2000;
    localparam logic [15:0] RST_PROBE_RECOVERY = 16'd750;
    localparam logic [15:0] RST_READY_DELAY    = 16'd250;
    localparam logic [15:0] RST_LOST_TIMEOUT   = 16'd10000;
    localparam logic [15:0] RST_LOST_CONFIRM   = 16'd1500;
    localparam logic [15:0] RST_FAST_WINDOW    = 16'd15000;
    localparam logic [15:0] RST_REINIT_IVL     = 16'd5000;

    // Age reported before any packet has been seen
    localparam logic [31:0] AGE_NONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [15:0] probe_ready_ms;
        logic [15:0] probe_search_ms;
        logic [15:0] probe_recovery_ms;
        logic [15:0] ready_delay_ms;
        logic [15:0] lost_timeout_ms;
        logic [15:0] lost_confirm_ms;
        logic [15:0] fast_window_ms;
        logic [15:0] reinit_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic        cmd;
        logic [31:0] now_ms;
        logic [1:0]  dev_type;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  link_state;
        logic [1:0]  cur_type;
        logic        connected;
        logic        probe_req;
        logic        reinit_req;
        logic        setup_req;
        logic [1:0]  publish_evt;
        logic [31:0] rx_age;
    } t_out_item;

endpackage

// File: hw/rtl/link_presence_watchdog.sv
// Top level of the link presence watchdog: request and result registers.
//
// Input channel (i_in_valid / o_in_ready / i_in) carries one request: a
// packet-seen event with its device type, or a poll, with a ms timestamp.
// Each request gives exactly one result on the output channel
// (o_out_valid / i_out_ready / o_out): link state, stored type, probe,
// reinit and setup pulses, publish event and receive age.
// Configuration port (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
// writes one 16-bit register per request; it is always ready and must be
// used only while no request is in flight.
// A request is captured in the input register and evaluated against the
// link state once the result register can take its result.
// One request per cycle is sustained while results are taken; the single
// pass of subtract-and-compare logic sets the clock period.
// Reset returns the registers to their defaults, the link to unknown with
// no packet seen, and empties both pipeline registers.
// While the receiver holds off, the result register keeps its value and
// the input register still takes one further request before o_in_ready
// falls; nothing is dropped.
module link_presence_watchdog (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  lpw_pkg::t_in_item              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output lpw_pkg::t_out_item             o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lpw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);
    import lpw_pkg::*;

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    logic      fire;
    t_cfg      cfg;
    t_out_item result;

    // Evaluate the held request once the result register can take it
    assign fire        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || fire;
    assign o_cfg_ready = 1'b1;

    lpw_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    lpw_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register: hold the request until it is evaluated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    // Result register: load on evaluation, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

// File: hw/rtl/lpw_cfg.sv
// Configuration register file of the link presence watchdog.
module lpw_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [lpw_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [15:0]                    i_wr_data,
    output lpw_pkg::t_cfg                  o_cfg
);
    import lpw_pkg::*;

    t_cfg r_cfg;

    // Load defaults on reset, take one register per write request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.probe_ready_ms     <= RST_PROBE_READY;
            r_cfg.probe_search_ms    <= RST_PROBE_SEARCH;
            r_cfg.probe_recovery_ms  <= RST_PROBE_RECOVERY;
            r_cfg.ready_delay_ms     <= RST_READY_DELAY;
            r_cfg.lost_timeout_ms    <= RST_LOST_TIMEOUT;
            r_cfg.lost_confirm_ms    <= RST_LOST_CONFIRM;
            r_cfg.fast_window_ms     <= RST_FAST_WINDOW;
            r_cfg.reinit_interval_ms <= RST_REINIT_IVL;
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_PROBE_READY:    r_cfg.probe_ready_ms     <= i_wr_data;
                REG_PROBE_SEARCH:   r_cfg.probe_search_ms    <= i_wr_data;
                REG_PROBE_RECOVERY: r_cfg.probe_recovery_ms  <= i_wr_data;
                REG_READY_DELAY:    r_cfg.ready_delay_ms     <= i_wr_data;
                REG_LOST_TIMEOUT:   r_cfg.lost_timeout_ms    <= i_wr_data;
                REG_LOST_CONFIRM:   r_cfg.lost_confirm_ms    <= i_wr_data;
                REG_FAST_WINDOW:    r_cfg.fast_window_ms     <= i_wr_data;
                REG_REINIT_IVL:     r_cfg.reinit_interval_ms <= i_wr_data;
                default:            r_cfg                    <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/lpw_engine.sv
// Link state tracker: timing checks, state update and result formation.
module lpw_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  lpw_pkg::t_in_item   i_item,
    input  lpw_pkg::t_cfg       i_cfg,
    output lpw_pkg::t_out_item  o_result
);
    import lpw_pkg::*;

    logic [1:0]  r_state,       n_state;
    logic [1:0]  r_type,        n_type;
    logic [31:0] r_rx_time,     n_rx_time;
    logic        r_rx_seen,     n_rx_seen;
    logic [31:0] r_detect_time, n_detect_time;
    logic [31:0] r_probe_time,  n_probe_time;
    logic [31:0] r_stale_time,  n_stale_time;
    logic        r_stale_pend,  n_stale_pend;
    logic [31:0] r_loss_time,   n_loss_time;
    logic        r_loss_valid,  n_loss_valid;
    logic [31:0] r_reinit_time, n_reinit_time;
    logic        r_setup_done,  n_setup_done;

    logic [31:0] now;
    logic [31:0] d_rx, d_reinit, d_loss, d_probe, d_detect, d_stale;
    logic [31:0] age;
    logic [15:0] interval;
    logic        conn;
    logic        probe, reinit, setup;
    logic [1:0]  publish;

    // Elapsed times, all modulo 2^32
    assign now      = i_item.now_ms;
    assign d_rx     = now - r_rx_time;
    assign d_reinit = now - r_reinit_time;
    assign d_loss   = now - r_loss_time;
    assign d_probe  = now - r_probe_time;
    assign d_detect = now - r_detect_time;
    assign d_stale  = now - r_stale_time;
    assign conn     = (r_state == ST_DETECTED) || (r_state == ST_READY);

    // Work out the next state and the result for the request in hand
    always_comb begin
        n_state       = r_state;
        n_type        = r_type;
        n_rx_time     = r_rx_time;
        n_rx_seen     = r_rx_seen;
        n_detect_time = r_detect_time;
        n_probe_time  = r_probe_time;
        n_stale_time  = r_stale_time;
        n_stale_pend  = r_stale_pend;
        n_loss_time   = r_loss_time;
        n_loss_valid  = r_loss_valid;
        n_reinit_time = r_reinit_time;
        n_setup_done  = r_setup_done;
        probe         = 1'b0;
        reinit        = 1'b0;
        setup         = 1'b0;
        publish       = EVT_NONE;
        interval      = i_cfg.probe_search_ms;
        age           = '0;

        if (i_item.cmd == CMD_PACKET) begin
            // Refresh the heartbeat, restart detection on a new peer or from unknown or lost
            n_rx_time     = now;
            n_rx_seen     = 1'b1;
            n_stale_pend  = 1'b0;
            n_loss_valid  = 1'b0;
            n_reinit_time = '0;
            if ((r_type != i_item.dev_type) || (r_state == ST_UNKNOWN) ||
                (r_state == ST_LOST)) begin
                n_type        = i_item.dev_type;
                n_state       = ST_DETECTED;
                n_detect_time = now;
                n_setup_done  = 1'b0;
                publish       = EVT_DETECTED;
            end
        end else begin
            age = r_rx_seen ? d_rx : AGE_NONE;

            // Pick the probe interval and pace reinit requests
            if (conn) begin
                interval = i_cfg.probe_ready_ms;
            end else if (r_state == ST_LOST) begin
                if (d_reinit >= {16'd0, i_cfg.reinit_interval_ms}) begin
                    n_reinit_time = now;
                    reinit        = 1'b1;
                end
                if (r_loss_valid && (d_loss < {16'd0, i_cfg.fast_window_ms})) begin
                    interval = i_cfg.probe_recovery_ms;
                end
            end else if (!r_rx_seen || (r_state == ST_UNKNOWN)) begin
                if (d_reinit >= {16'd0, i_cfg.reinit_interval_ms}) begin
                    n_reinit_time = now;
                    reinit        = 1'b1;
                end
            end

            if (d_probe >= {16'd0, interval}) begin
                n_probe_time = now;
                probe        = 1'b1;
            end

            // Settle to ready on a fresh heartbeat, confirm loss on a stale one
            if (r_rx_seen) begin
                if (d_rx <= {16'd0, i_cfg.lost_timeout_ms}) begin
                    n_stale_pend = 1'b0;
                    if ((r_state == ST_DETECTED) &&
                        (d_detect >= {16'd0, i_cfg.ready_delay_ms})) begin
                        n_state = ST_READY;
                        publish = EVT_CONNECTED;
                        if (!r_setup_done && (r_type == DEV_BODY)) begin
                            n_setup_done = 1'b1;
                            setup        = 1'b1;
                        end
                    end
                end else if (conn) begin
                    if (!r_stale_pend) begin
                        n_stale_pend = 1'b1;
                        n_stale_time = now;
                    end else if (d_stale >= {16'd0, i_cfg.lost_confirm_ms}) begin
                        n_state      = ST_LOST;
                        n_setup_done = 1'b0;
                        n_stale_pend = 1'b0;
                        n_loss_time  = now;
                        n_loss_valid = 1'b1;
                        reinit       = 1'b1;
                        publish      = EVT_LOST;
                    end
                end
            end
        end
    end

    // Form the result from the updated state
    always_comb begin
        o_result.link_state  = n_state;
        o_result.cur_type    = n_type;
        o_result.connected   = (n_state == ST_DETECTED) || (n_state == ST_READY);
        o_result.probe_req   = probe;
        o_result.reinit_req  = reinit;
        o_result.setup_req   = setup;
        o_result.publish_evt = publish;
        o_result.rx_age      = age;
    end

    // Commit the state when a request goes through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_UNKNOWN;
            r_type        <= '0;
            r_rx_time     <= '0;
            r_rx_seen     <= 1'b0;
            r_detect_time <= '0;
            r_probe_time  <= '0;
            r_stale_time  <= '0;
            r_stale_pend  <= 1'b0;
            r_loss_time   <= '0;
            r_loss_valid  <= 1'b0;
            r_reinit_time <= '0;
            r_setup_done  <= 1'b0;
        end else if (i_fire) begin
            r_state       <= n_state;
            r_type        <= n_type;
            r_rx_time     <= n_rx_time;
            r_rx_seen     <= n_rx_seen;
            r_detect_time <= n_detect_time;
            r_probe_time  <= n_probe_time;
            r_stale_time  <= n_stale_time;
            r_stale_pend  <= n_stale_pend;
            r_loss_time   <= n_loss_time;
            r_loss_valid  <= n_loss_valid;
            r_reinit_time <= n_reinit_time;
            r_setup_done  <= n_setup_done;
        end
    end

    // Setup is asked for once: the flag is set after the pulse
    a_setup_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.setup_req) |=> r_setup_done)
        else $error("setup flag not set after setup request");

    // A declared loss leaves the link lost with a valid loss time
    a_loss_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (o_result.publish_evt == EVT_LOST)) |=>
        ((r_state == ST_LOST) && r_loss_valid && !r_stale_pend))
        else $error("loss event without lost state");

    // A packet always leaves the link seen and out of the unknown state
    a_packet_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_item.cmd == CMD_PACKET)) |=>
        (r_rx_seen && !r_loss_valid && (r_state != ST_UNKNOWN) &&
         (r_state != ST_LOST)))
        else $error("packet did not refresh link state");

    // Pulses on a packet request stay low
    a_packet_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_item.cmd == CMD_PACKET)) |->
        (!o_result.probe_req && !o_result.reinit_req && !o_result.setup_req))
        else $error("pulse raised on packet request");

endmodule
